>>> rtl/core/ltt_pkg.sv
// Shared types and token codes for the logic-term tokenizer.
`default_nettype none

package ltt_pkg;

    localparam logic [2:0] KIND_EOL        = 3'd0;
    localparam logic [2:0] KIND_SEPARATOR  = 3'd1;
    localparam logic [2:0] KIND_LIST_OPEN  = 3'd2;
    localparam logic [2:0] KIND_LIST_CLOSE = 3'd3;
    localparam logic [2:0] KIND_VARIABLE   = 3'd4;
    localparam logic [2:0] KIND_ATOM       = 3'd5;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [2:0] token_kind;
        logic [7:0] text_byte;
        logic       byte_valid;
        logic       token_start;
        logic       token_end;
        logic       lex_error;
    } t_out;

    // Events produced by one input item, in order.
    typedef struct packed {
        logic [1:0] num;
        t_out       ev0;
        t_out       ev1;
    } t_push;

endpackage

`default_nettype wire

>>> rtl/core/logic_term_tokenizer.sv
// Top level of the logic-term tokenizer: front lexer, event queue, output stage.
//
// Input channel: one source byte per item (i_in.char_in) with an end mark
// (i_in.end_of_input); accepted when i_in_valid is high and o_in_stall low.
// Output channel: one token event per item on o_out, accepted when
// o_out_valid is high and i_out_stall low.
// Each input byte gives zero, one or two events. The lexer state updates in
// the accepting cycle and its events enter a QUEUE_DEPTH entry queue; an
// output register then presents them. The first event of a byte passes through
// the queue and then the output register before it is presented.
// One byte is taken every cycle as long as the queue holds at least two free
// entries; while the receiver does not stall, the output register gives one event
// per cycle, so a long run of two-event bytes slows the input to that rate.
// Reset (i_rst_n low at a clock edge) returns the lexer to idle between
// tokens and empties the queue and the output register.
// While the receiver stalls, the presented event holds; the queue fills and
// o_in_stall rises once fewer than two entries are free.
`default_nettype none

module logic_term_tokenizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ltt_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ltt_pkg::t_out      o_out
);
    import ltt_pkg::*;

    t_push push;
    t_out  head;
    logic  empty;
    logic  room;
    logic  pop;
    logic  take;

    assign o_in_stall = !room;
    assign take       = i_in_valid && room;

    ltt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_in    (i_in),
        .o_push  (push)
    );

    ltt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_room  (room)
    );

    ltt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> rtl/core/ltt_front.sv
// Front end: lexer state machine, turns each input item into up to two events.
`default_nettype none

module ltt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire ltt_pkg::t_in  i_in,
    output ltt_pkg::t_push     o_push
);
    import ltt_pkg::*;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    typedef enum logic [2:0] {
        M_IDLE,
        M_WORD,
        M_QUOTE,
        M_ESC,
        M_HEX1,
        M_HEX2,
        M_ERR
    } t_mode;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd0;
        if (is_digit(c)) begin
            v = {1'b1, 4'(c - 8'h30)};
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = {1'b1, 4'(c - 8'h57)};
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = {1'b1, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h30:   r = 8'd0;
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h74:   r = 8'd9;
            8'h6E:   r = 8'd10;
            8'h76:   r = 8'd11;
            8'h66:   r = 8'd12;
            8'h72:   r = 8'd13;
            default: r = c;
        endcase
        return r;
    endfunction

    t_mode      r_mode, n_mode;
    logic       r_dbl, n_dbl;
    logic       r_var, n_var;
    logic [3:0] r_nib, n_nib;
    logic       r_sp, n_sp;

    // Start-of-token decode, independent of state.
    logic       b_emit;
    t_out       b_ev;
    t_mode      b_mode;
    logic       b_word;
    logic       b_var;
    logic       b_quote;
    logic       b_dbl;

    logic [7:0] c;
    logic [4:0] hex;
    logic [2:0] word_kind;
    logic [7:0] close_ch;
    t_out       ev0, ev1;
    logic [1:0] num;

    assign c         = i_in.char_in;
    assign hex       = hex_value(c);
    assign word_kind = r_var ? KIND_VARIABLE : KIND_ATOM;
    assign close_ch  = r_dbl ? CH_DQUOTE : CH_SQUOTE;

    always_comb begin
        b_emit  = 1'b0;
        b_ev    = '0;
        b_mode  = M_IDLE;
        b_word  = 1'b0;
        b_var   = is_upper(c) || (c == CH_UNDER);
        b_quote = 1'b0;
        b_dbl   = (c == CH_DQUOTE);
        priority if (is_space(c)) begin
            b_emit = 1'b0;
        end else if (c == CH_SEMI || c == CH_BAR || c == CH_LBRK || c == CH_RBRK) begin
            b_emit           = 1'b1;
            b_ev.token_start = 1'b1;
            b_ev.token_end   = 1'b1;
            priority if (c == CH_SEMI) begin
                b_ev.token_kind = KIND_EOL;
            end else if (c == CH_BAR) begin
                b_ev.token_kind = KIND_SEPARATOR;
            end else if (c == CH_LBRK) begin
                b_ev.token_kind = KIND_LIST_OPEN;
            end else begin
                b_ev.token_kind = KIND_LIST_CLOSE;
            end
        end else if (b_var || is_lower(c)) begin
            b_emit           = 1'b1;
            b_word           = 1'b1;
            b_mode           = M_WORD;
            b_ev.token_kind  = b_var ? KIND_VARIABLE : KIND_ATOM;
            b_ev.text_byte   = c;
            b_ev.byte_valid  = 1'b1;
            b_ev.token_start = 1'b1;
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            b_quote = 1'b1;
            b_mode  = M_QUOTE;
        end else begin
            b_emit         = 1'b1;
            b_ev.lex_error = 1'b1;
            b_mode         = M_ERR;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_dbl  = r_dbl;
        n_var  = r_var;
        n_nib  = r_nib;
        n_sp   = r_sp;
        ev0    = '0;
        ev1    = '0;
        num    = 2'd0;
        if (i_in.end_of_input) begin
            if (r_mode == M_WORD) begin
                ev0.token_kind = word_kind;
                ev0.token_end  = 1'b1;
                num            = 2'd1;
            end else if (r_mode == M_QUOTE || r_mode == M_ESC ||
                         r_mode == M_HEX1 || r_mode == M_HEX2) begin
                ev0.lex_error = 1'b1;
                num           = 2'd1;
            end
            n_mode = M_IDLE;
            n_dbl  = 1'b0;
            n_var  = 1'b0;
            n_nib  = 4'd0;
            n_sp   = 1'b0;
        end else begin
            unique case (r_mode)
                M_IDLE: begin
                    ev0    = b_ev;
                    num    = {1'b0, b_emit};
                    n_mode = b_mode;
                    if (b_word) begin
                        n_var = b_var;
                    end
                    if (b_quote) begin
                        n_dbl = b_dbl;
                        n_sp  = 1'b1;
                    end
                end
                M_WORD: begin
                    ev0.token_kind = word_kind;
                    if (is_upper(c) || is_lower(c) || is_digit(c) || c == CH_UNDER) begin
                        ev0.text_byte  = c;
                        ev0.byte_valid = 1'b1;
                        num            = 2'd1;
                    end else begin
                        // Close the word, then lex this byte as a new token.
                        ev0.token_end = 1'b1;
                        ev1           = b_ev;
                        num           = b_emit ? 2'd2 : 2'd1;
                        n_mode        = b_mode;
                        if (b_word) begin
                            n_var = b_var;
                        end
                        if (b_quote) begin
                            n_dbl = b_dbl;
                            n_sp  = 1'b1;
                        end
                    end
                end
                M_QUOTE: begin
                    ev0.token_kind  = KIND_ATOM;
                    ev0.token_start = r_sp;
                    if (c == close_ch) begin
                        ev0.token_end = 1'b1;
                        num           = 2'd1;
                        n_sp          = 1'b0;
                        n_mode        = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        ev0    = '0;
                        n_mode = M_ESC;
                    end else begin
                        ev0.text_byte  = c;
                        ev0.byte_valid = 1'b1;
                        num            = 2'd1;
                        n_sp           = 1'b0;
                    end
                end
                M_ESC: begin
                    if (c == CH_X) begin
                        n_mode = M_HEX1;
                    end else begin
                        ev0.token_kind  = KIND_ATOM;
                        ev0.token_start = r_sp;
                        ev0.text_byte   = escape_map(c);
                        ev0.byte_valid  = 1'b1;
                        num             = 2'd1;
                        n_sp            = 1'b0;
                        n_mode          = M_QUOTE;
                    end
                end
                M_HEX1: begin
                    if (!hex[4]) begin
                        ev0.lex_error = 1'b1;
                        num           = 2'd1;
                        n_mode        = M_ERR;
                    end else begin
                        n_nib  = hex[3:0];
                        n_mode = M_HEX2;
                    end
                end
                M_HEX2: begin
                    if (!hex[4]) begin
                        ev0.lex_error = 1'b1;
                        num           = 2'd1;
                        n_mode        = M_ERR;
                    end else begin
                        ev0.token_kind  = KIND_ATOM;
                        ev0.token_start = r_sp;
                        ev0.text_byte   = {r_nib, hex[3:0]};
                        ev0.byte_valid  = 1'b1;
                        num             = 2'd1;
                        n_sp            = 1'b0;
                        n_mode          = M_QUOTE;
                    end
                end
                default: begin
                    // Error: drop bytes until end of input.
                    n_mode = M_ERR;
                end
            endcase
        end
    end

    always_comb begin
        o_push.num = i_take ? num : 2'd0;
        o_push.ev0 = ev0;
        o_push.ev1 = ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_dbl  <= 1'b0;
            r_var  <= 1'b0;
            r_nib  <= 4'd0;
            r_sp   <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_dbl  <= n_dbl;
            r_var  <= n_var;
            r_nib  <= n_nib;
            r_sp   <= n_sp;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ltt_queue.sv
// Event queue between front and back: two writes and one read per cycle.
`default_nettype none

module ltt_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ltt_pkg::t_push i_push,
    input  wire logic           i_pop,
    output ltt_pkg::t_out       o_head,
    output logic                o_empty,
    output logic                o_room
);
    import ltt_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = PW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Step a pointer by zero, one or two entries, wrap at DEPTH.
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [1:0] k);
        logic [SW-1:0] s;
        s = {1'b0, p} + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    t_out          r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] wp_next;

    assign wp_next = advance(r_wp, 2'd1);
    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_count == '0);
    // Room for the two events one item can cause.
    assign o_room  = (r_count <= CW'(DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wp] <= i_push.ev0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wp_next] <= i_push.ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= advance(r_wp, i_push.num);
            r_rp    <= advance(r_rp, {1'b0, i_pop});
            r_count <= r_count + CW'(i_push.num) - CW'(i_pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ltt_back.sv
// Back end: output register that hands queued events to the receiver.
`default_nettype none

module ltt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ltt_pkg::t_out i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ltt_pkg::t_out      o_out
);
    import ltt_pkg::*;

    logic r_valid;
    t_out r_out;

    // Load when the register is empty or being taken this cycle.
    assign o_pop       = !i_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_head;
        end
    end

endmodule

`default_nettype wire

>>> tb/logic_term_tokenizer_test.sv
// Self-checking testbench for the logic-term tokenizer: byte stream in, token events out.
module logic_term_tokenizer_test;
    import ltt_pkg::*;

    typedef enum logic [2:0] {
        LX_IDLE, LX_WORD, LX_QUOTE, LX_ESC, LX_HEX1, LX_HEX2, LX_ERR
    } t_lex_mode;

    typedef struct {
        t_in item;
        int  gap;
        bit  drain;
    } t_source_item;

    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_BAR    = "|";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_BSLASH = "\\";
    localparam logic [7:0] CH_X      = "x";
    localparam logic [7:0] CH_SQUOTE = "'";
    localparam logic [7:0] CH_DQUOTE = "\"";
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out;

    logic_term_tokenizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Lexer state mirrored by the predictor
    t_lex_mode  lx_mode = LX_IDLE;
    logic       lx_double = 1'b0;
    logic       lx_variable = 1'b0;
    logic [3:0] lx_nibble = 4'd0;
    logic       lx_start = 1'b0;

    t_out         token_events_due[$];
    t_source_item source_items[$];
    int           mismatches = 0;
    bit           in_busy = 1'b0;
    bit           send_calm = 1'b0;
    bit           drain_next = 1'b0;
    int           items_queued = 0;
    int           out_gap = 0;
    int           calm_left = 0;
    bit           out_calm = 1'b0;

    function automatic bit is_upper(logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic bit is_lower(logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (is_digit(c)) return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] unescape(logic [7:0] c);
        case (c)
            "0": return 8'd0;
            "a": return 8'd7;
            "b": return 8'd8;
            "t": return 8'd9;
            "n": return 8'd10;
            "v": return 8'd11;
            "f": return 8'd12;
            "r": return 8'd13;
            default: return c;
        endcase
    endfunction

    function automatic logic [2:0] word_kind();
        return lx_variable ? KIND_VARIABLE : KIND_ATOM;
    endfunction

    function automatic void add_event(logic [2:0] kind, logic [7:0] txt, logic bv,
                                      logic st, logic en, logic err);
        t_out ev;
        ev.token_kind  = kind;
        ev.text_byte   = txt;
        ev.byte_valid  = bv;
        ev.token_start = st;
        ev.token_end   = en;
        ev.lex_error   = err;
        token_events_due.insert(token_events_due.size(), ev);
    endfunction

    function automatic void lex_fail();
        add_event(KIND_EOL, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1);
        lx_mode = LX_ERR;
    endfunction

    function automatic void quote_byte(logic [7:0] b);
        add_event(KIND_ATOM, b, 1'b1, lx_start, 1'b0, 1'b0);
        lx_start = 1'b0;
        lx_mode  = LX_QUOTE;
    endfunction

    function automatic void open_token(logic [7:0] c);
        if (is_blank(c)) return;
        if (c == CH_SEMI)
            add_event(KIND_EOL, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        else if (c == CH_BAR)
            add_event(KIND_SEPARATOR, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        else if (c == CH_LBRACK)
            add_event(KIND_LIST_OPEN, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        else if (c == CH_RBRACK)
            add_event(KIND_LIST_CLOSE, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        else if (is_upper(c) || c == CH_UNDER || is_lower(c)) begin
            lx_variable = is_upper(c) || c == CH_UNDER;
            lx_mode = LX_WORD;
            add_event(word_kind(), c, 1'b1, 1'b1, 1'b0, 1'b0);
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            lx_double = (c == CH_DQUOTE);
            lx_start = 1'b1;
            lx_mode = LX_QUOTE;
        end else
            lex_fail();
    endfunction

    // Work out the token events that one accepted item causes
    function automatic void lex_item(t_in it);
        logic [7:0] c;
        int h;
        c = it.char_in;
        if (it.end_of_input) begin
            if (lx_mode == LX_WORD)
                add_event(word_kind(), 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
            else if (lx_mode inside {LX_QUOTE, LX_ESC, LX_HEX1, LX_HEX2})
                lex_fail();
            lx_mode = LX_IDLE;
            lx_double = 1'b0;
            lx_variable = 1'b0;
            lx_nibble = 4'd0;
            lx_start = 1'b0;
            return;
        end
        case (lx_mode)
            LX_IDLE: open_token(c);
            LX_WORD: begin
                if (is_upper(c) || is_lower(c) || is_digit(c) || c == CH_UNDER)
                    add_event(word_kind(), c, 1'b1, 1'b0, 1'b0, 1'b0);
                else begin
                    add_event(word_kind(), 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
                    lx_mode = LX_IDLE;
                    open_token(c);
                end
            end
            LX_QUOTE: begin
                if (c == (lx_double ? CH_DQUOTE : CH_SQUOTE)) begin
                    add_event(KIND_ATOM, 8'd0, 1'b0, lx_start, 1'b1, 1'b0);
                    lx_start = 1'b0;
                    lx_mode = LX_IDLE;
                end else if (c == CH_BSLASH)
                    lx_mode = LX_ESC;
                else
                    quote_byte(c);
            end
            LX_ESC: begin
                if (c == CH_X)
                    lx_mode = LX_HEX1;
                else
                    quote_byte(unescape(c));
            end
            LX_HEX1: begin
                h = hex_nibble(c);
                if (h < 0)
                    lex_fail();
                else begin
                    lx_nibble = h[3:0];
                    lx_mode = LX_HEX2;
                end
            end
            LX_HEX2: begin
                h = hex_nibble(c);
                if (h < 0)
                    lex_fail();
                else
                    quote_byte({lx_nibble, h[3:0]});
            end
            default: lx_mode = LX_ERR;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(9, 30);
    endfunction

    function automatic bit field_ok(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Sender: present items from the source queue, predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                lex_item(i_in);
                in_busy = 1'b0;
            end
            if (!in_busy && source_items.size() > 0) begin
                if (source_items[0].gap > 0)
                    source_items[0].gap = source_items[0].gap - 1;
                else if (!source_items[0].drain || token_events_due.size() == 0) begin
                    i_in <= source_items[0].item;
                    void'(source_items.pop_front());
                    in_busy = 1'b1;
                end
            end
            i_in_valid <= in_busy;
        end
    end

    // Receiver: check each event against the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (token_events_due.size() == 0) begin
                    $display("%0t: unexpected event: actual %0h", $time, o_out);
                    mismatches++;
                end else begin
                    t_out want;
                    bit good;
                    want = token_events_due.pop_front();
                    good = 1'b1;
                    good &= field_ok("token_kind", want.token_kind, o_out.token_kind);
                    good &= field_ok("text_byte", want.text_byte, o_out.text_byte);
                    good &= field_ok("byte_valid", want.byte_valid, o_out.byte_valid);
                    good &= field_ok("token_start", want.token_start, o_out.token_start);
                    good &= field_ok("token_end", want.token_end, o_out.token_end);
                    good &= field_ok("lex_error", want.lex_error, o_out.lex_error);
                    if (!good) mismatches++;
                end
            end
            if (calm_left == 0) begin
                out_calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 400);
            end else
                calm_left--;
            if (out_gap == 0 && !out_calm && $urandom_range(0, 99) < 25)
                out_gap = gap_len();
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_item(logic [7:0] c, bit eoi);
        t_source_item s;
        s.item.char_in = c;
        s.item.end_of_input = eoi;
        s.gap = (send_calm || $urandom_range(0, 99) >= 30) ? 0 : gap_len();
        s.drain = drain_next;
        drain_next = 1'b0;
        source_items.insert(source_items.size(), s);
        items_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] word_char();
        int k;
        k = $urandom_range(0, 62);
        if (k < 26) return 8'("A" + k);
        if (k < 52) return 8'("a" + k - 26);
        if (k < 62) return 8'("0" + k - 52);
        return CH_UNDER;
    endfunction

    task automatic queue_quoted();
        string      hexdig;
        string      escs;
        logic [7:0] delim;
        logic [7:0] c;
        int         r;
        hexdig = "0123456789abcdefABCDEF";
        escs = "0abtnvfr";
        delim = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        queue_item(delim, 1'b0);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                do c = 8'($urandom_range(0, 255)); while (c == delim || c == CH_BSLASH);
                queue_item(c, 1'b0);
            end else if (r < 80) begin
                queue_item(CH_BSLASH, 1'b0);
                c = $urandom_range(0, 1) ? escs[$urandom_range(0, 7)] : 8'($urandom_range(0, 255));
                queue_item(c, 1'b0);
                if (c == CH_X) begin
                    queue_item(hexdig[$urandom_range(0, 21)], 1'b0);
                    queue_item(hexdig[$urandom_range(0, 21)], 1'b0);
                end
            end else begin
                queue_item(CH_BSLASH, 1'b0);
                queue_item(CH_X, 1'b0);
                // Corrupt a digit now and then to hit the bad-escape error
                c = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                 : hexdig[$urandom_range(0, 21)];
                queue_item(c, 1'b0);
                c = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                 : hexdig[$urandom_range(0, 21)];
                queue_item(c, 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0)
            queue_item(delim, 1'b0);
    endtask

    task automatic queue_token();
        logic [7:0] punct [4];
        int         r;
        punct = '{CH_SEMI, CH_BAR, CH_LBRACK, CH_RBRACK};
        r = $urandom_range(0, 99);
        if (r < 15)
            queue_item(($urandom_range(0, 5) == 5) ? CH_SPACE : 8'($urandom_range(9, 13)), 1'b0);
        else if (r < 30)
            queue_item(punct[$urandom_range(0, 3)], 1'b0);
        else if (r < 60) begin
            case ($urandom_range(0, 2))
                0: queue_item(8'("A" + $urandom_range(0, 25)), 1'b0);
                1: queue_item(CH_UNDER, 1'b0);
                default: queue_item(8'("a" + $urandom_range(0, 25)), 1'b0);
            endcase
            repeat ($urandom_range(0, 7)) queue_item(word_char(), 1'b0);
        end else if (r < 90)
            queue_quoted();
        else
            queue_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        send_calm = 1'b1;
        // Variable closed by an end-of-line byte, then a list open
        queue_text("Xa_9;[");
        // Hex escape with mixed case, named escape, other quote inside
        queue_text("'\\xFf\\n\"'");
        // Empty quoted atom, whitespace, separator, list close
        queue_text("\"\"\t|]");
        // Bad hex digit, then end of input in the error state
        queue_text("'\\xg");
        queue_item(8'hFF, 1'b1);
        // End of input closes an open word
        queue_item("z", 1'b0);
        queue_item(8'h00, 1'b1);
        // End of input inside a hex escape
        queue_text("\"\\x");
        queue_item(8'h00, 1'b1);
        queue_item(8'h80, 1'b0);
        queue_item(8'h00, 1'b1);

        drain_next = 1'b1;
        while (items_queued < 1330) begin
            send_calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 15) == 0) drain_next = 1'b1;
            repeat ($urandom_range(1, 12)) queue_token();
            queue_item(8'($urandom_range(0, 255)), 1'b1);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (source_items.size() > 0 || in_busy || token_events_due.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && token_events_due.size() == 0) begin
            $display("[logic_term_tokenizer] OK");
        end else begin
            $display("%0t: %0d mismatches, %0d events still due", $time, mismatches,
                     token_events_due.size());
            $display("[logic_term_tokenizer] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("[logic_term_tokenizer] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ltt_pkg.sv
rtl/core/ltt_front.sv
rtl/core/ltt_queue.sv
rtl/core/ltt_back.sv
rtl/core/logic_term_tokenizer.sv
tb/logic_term_tokenizer_test.sv
